[rtl/set_assoc_lru_cache_lookup_core_macros.svh]
// Assertion helpers used by the checker file
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define SALC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset
`define SALC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/salc_pkg.sv]
`default_nettype none
package salc_pkg;

    // default geometry limits
    localparam int DEF_MAX_SETS = 256;
    localparam int DEF_MAX_WAYS = 8;

    // field widths
    localparam int ADDR_W    = 64;
    localparam int SET_IDX_W = 12;   // enough for the largest set count
    localparam int CNT_W     = 32;
    localparam int OUT_W     = 72;

    // configuration register indexes
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [1:0] CFG_WAY_BITS    = 2'd2;

    // one classified access in the queue
    typedef struct packed {
        logic [ADDR_W-1:0]    tag;
        logic [SET_IDX_W-1:0] set;
    } item_t;

    // front to back configuration view
    typedef struct packed {
        logic [1:0] way_bits;
        logic       flush;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } st_t;

endpackage
`default_nettype wire

[rtl/salc_ram.sv]
`default_nettype none
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/salc_queue.sv]
`default_nettype none
module salc_queue import salc_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire item_t wr_item,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output item_t      rd_item
);

    item_t      q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = q_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

[rtl/salc_front.sv]
`default_nettype none
module salc_front import salc_pkg::*; #(
    parameter int MAX_SETS = DEF_MAX_SETS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [3:0]        cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ADDR_W-1:0] s_tdata,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output item_t                  q_item,
    output cfg_t                   cfg
);

    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_AW = (SB_MAX > 0) ? SB_MAX : 1;

    logic [3:0]        offset_bits_reg, offset_bits_next;
    logic [3:0]        set_bits_reg, set_bits_next;
    logic [1:0]        way_bits_reg, way_bits_next;
    logic              flush;
    logic [3:0]        sb_eff;
    logic [ADDR_W-1:0] shifted;
    logic [SET_AW-1:0] set_mask;
    logic [4:0]        tag_sh;

    // configuration registers; any known index flushes the cache
    always_comb begin
        offset_bits_next = offset_bits_reg;
        set_bits_next    = set_bits_reg;
        way_bits_next    = way_bits_reg;
        flush            = 1'b0;
        if (cfg_we) begin
            case (cfg_index)
                CFG_OFFSET_BITS: begin
                    offset_bits_next = cfg_wdata;
                    flush            = 1'b1;
                end
                CFG_SET_BITS: begin
                    set_bits_next = cfg_wdata;
                    flush         = 1'b1;
                end
                CFG_WAY_BITS: begin
                    way_bits_next = cfg_wdata[1:0];
                    flush         = 1'b1;
                end
                default: begin
                    flush = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= 4'd0;
            set_bits_reg    <= 4'd0;
            way_bits_reg    <= 2'd0;
        end else begin
            offset_bits_reg <= offset_bits_next;
            set_bits_reg    <= set_bits_next;
            way_bits_reg    <= way_bits_next;
        end
    end

    assign cfg.way_bits = way_bits_reg;
    assign cfg.flush    = flush;

    // address split: offset dropped, set index, tag above the used set bits
    always_comb begin
        sb_eff   = (int'(set_bits_reg) > SB_MAX) ? 4'(SB_MAX) : set_bits_reg;
        shifted  = s_tdata >> offset_bits_reg;
        set_mask = ~({SET_AW{1'b1}} << sb_eff);
        tag_sh   = {1'b0, offset_bits_reg} + {1'b0, sb_eff};
        q_item.set = SET_IDX_W'(shifted[SET_AW-1:0] & set_mask);
        q_item.tag = s_tdata >> tag_sh;
    end

    assign q_valid  = s_tvalid;
    assign s_tready = q_ready;

endmodule
`default_nettype wire

[rtl/salc_back.sv]
`default_nettype none
module salc_back import salc_pkg::*; #(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  wire item_t      q_item,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_AW = (SB_MAX > 0) ? SB_MAX : 1;
    localparam int ROWS   = 2 ** SB_MAX;
    localparam int WB_MAX = $clog2(MAX_WAYS + 1) - 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W   = WAY_W + 1;
    localparam int TAG_RW = MAX_WAYS * ADDR_W;
    localparam int META_W = MAX_WAYS * (WAY_W + 1);

    typedef logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_row_t;
    typedef logic [MAX_WAYS-1:0][WAY_W-1:0]  rank_row_t;

    st_t               st_reg, st_next;
    logic [SET_AW-1:0] set_reg, set_next;
    logic [ADDR_W-1:0] tag_reg, tag_next;
    logic              rowv_reg [ROWS];
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [CNT_W-1:0]  miss_reg, miss_next;
    logic [CNT_W-1:0]  acc_reg, acc_next;

    logic              rd_en, wr_en;
    tag_row_t          tag_rd, tag_wr;
    logic [META_W-1:0] meta_rd, meta_wr, meta;
    logic [MAX_WAYS-1:0] valid, valid_new, act;
    rank_row_t         rank, rank_new;
    logic [1:0]        wb_eff;
    logic [NW_W-1:0]   nways, old_rank;
    logic              hit, found_free;
    logic [WAY_W-1:0]  hit_way, free_way, lru_way, chosen;
    logic [WAY_W-1:0]  best;

    // tag row and state row memories, one row per set
    salc_ram #(.WIDTH(TAG_RW), .DEPTH(ROWS)) u_tag_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (set_reg),
        .wdata (tag_wr),
        .re    (rd_en),
        .raddr (q_item.set[SET_AW-1:0]),
        .rdata (tag_rd)
    );

    salc_ram #(.WIDTH(META_W), .DEPTH(ROWS)) u_meta_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (set_reg),
        .wdata (meta_wr),
        .re    (rd_en),
        .raddr (q_item.set[SET_AW-1:0]),
        .rdata (meta_rd)
    );

    // lookup, victim choice and LRU update for the set row just read
    always_comb begin
        meta   = rowv_reg[set_reg] ? meta_rd : '0;
        valid  = meta[MAX_WAYS-1:0];
        rank   = rank_row_t'(meta[META_W-1:MAX_WAYS]);
        wb_eff = (int'(cfg.way_bits) > WB_MAX) ? 2'(WB_MAX) : cfg.way_bits;
        nways  = NW_W'(1) << wb_eff;
        for (int w = 0; w < MAX_WAYS; w++) begin
            act[w] = NW_W'(w) < nways;
        end

        hit      = 1'b0;
        hit_way  = '0;
        found_free = 1'b0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (act[w] && valid[w] && tag_rd[w] == tag_reg) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (act[w] && !valid[w]) begin
                found_free = 1'b1;
                free_way   = WAY_W'(w);
            end
        end

        best    = '0;
        lru_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (act[w] && rank[w] > best) begin
                best    = rank[w];
                lru_way = WAY_W'(w);
            end
        end

        if (hit) begin
            chosen = hit_way;
        end else if (found_free) begin
            chosen = free_way;
        end else begin
            chosen = lru_way;
        end

        old_rank  = valid[chosen] ? {1'b0, rank[chosen]} : nways;
        rank_new  = rank;
        valid_new = valid;
        tag_wr    = tag_rd;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) != chosen && act[w] && valid[w] && {1'b0, rank[w]} < old_rank) begin
                rank_new[w] = rank[w] + 1'b1;
            end
        end
        rank_new[chosen]  = '0;
        valid_new[chosen] = 1'b1;
        tag_wr[chosen]    = tag_reg;
        meta_wr = {rank_new, valid_new};
    end

    // sequencer: pop and read in idle, compare and write back in look
    always_comb begin
        st_next       = st_reg;
        set_next      = set_reg;
        tag_next      = tag_reg;
        q_ready       = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        miss_next     = miss_reg;
        acc_next      = acc_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (st_reg)
            ST_IDLE: begin
                if (q_valid && (!m_tvalid_reg || m_tready)) begin
                    q_ready  = 1'b1;
                    rd_en    = 1'b1;
                    set_next = q_item.set[SET_AW-1:0];
                    tag_next = q_item.tag;
                    st_next  = ST_LOOK;
                end
            end
            ST_LOOK: begin
                wr_en     = 1'b1;
                acc_next  = (acc_reg == '1) ? acc_reg : acc_reg + 1'b1;
                miss_next = (hit || miss_reg == '1) ? miss_reg : miss_reg + 1'b1;
                m_tdata_next = {3'b000, acc_next, miss_next,
                                !hit && !found_free, 3'(chosen), hit};
                m_tvalid_next = 1'b1;
                st_next       = ST_IDLE;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            miss_reg     <= '0;
            acc_reg      <= '0;
        end else begin
            st_reg       <= st_next;
            m_tvalid_reg <= m_tvalid_next;
            miss_reg     <= miss_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        set_reg     <= set_next;
        tag_reg     <= tag_next;
        m_tdata_reg <= m_tdata_next;
    end

    // per-row valid flags; an unwritten row reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.flush) begin
            for (int r = 0; r < ROWS; r++) begin
                rowv_reg[r] <= 1'b0;
            end
        end else if (wr_en) begin
            rowv_reg[set_reg] <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

[rtl/set_assoc_lru_cache_lookup_core.sv]
`default_nettype none
// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | s_tdata[63:0] address
// m_       | out | m_tvalid/m_tready  | m_tdata: hit, way_used[3], evicted, miss_total[32],
//          |     |                    |          access_total[32], zero pad
// cfg_     | in  | cfg_we             | cfg_index, cfg_wdata
//
// Each access first reads the set's tag and LRU rows, then compares, picks the way
// and writes both rows back.
// Reset clears the configuration, the counters and every row's valid flag.
// A two-entry queue keeps taking addresses, until it is full, while the lookup side waits on m_tready.
module set_assoc_lru_cache_lookup_core import salc_pkg::*; #(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ADDR_W-1:0] s_tdata,   // [63:0] address
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // [0] hit, [3:1] way_used, [4] evicted,
                                              // [36:5] miss_total, [68:37] access_total
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [3:0]        cfg_wdata
);

    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    item_t fq_item, qb_item;
    cfg_t  cfg;

    salc_front #(.MAX_SETS(MAX_SETS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item),
        .cfg       (cfg)
    );

    salc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    salc_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_item   (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

[rtl/salc_checker.sv]
`default_nettype none
`include "set_assoc_lru_cache_lookup_core_macros.svh"
module salc_checker import salc_pkg::*; (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // no result shows up right after reset
    `SALC_ASSERT_NR(a_rst_quiet, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    // a hit never evicts
    `SALC_ASSERT(a_hit_no_evict, aclk, aresetn, m_tvalid |-> !(m_tdata[0] && m_tdata[4]), "hit with eviction")
    // misses never outnumber accesses
    `SALC_ASSERT(a_cnt_order, aclk, aresetn, m_tvalid |-> m_tdata[36:5] <= m_tdata[68:37], "miss count above access count")
    // a stalled result holds
    `SALC_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind set_assoc_lru_cache_lookup_core salc_checker u_chk (.*);
`default_nettype wire

[tb/tb_set_assoc_lru_cache_lookup_core.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_set_assoc_lru_cache_lookup_core;
    import salc_pkg::*;

    localparam int NSETS = 256;
    localparam int NWAYS = 8;
    localparam int CYCLE_LIMIT = 400000;
    // register index past the end of the list
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way_used;
        logic        evicted;
        logic [31:0] miss_total;
        logic [31:0] access_total;
    } lookup_res_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [ADDR_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = CFG_OFFSET_BITS;
    logic [3:0]        cfg_wdata = '0;

    set_assoc_lru_cache_lookup_core dut (.*);

    always #5 aclk = ~aclk;

    // shadow cache state
    logic [63:0] shadow_tag [NSETS*NWAYS];
    logic        shadow_valid [NSETS*NWAYS];
    logic [2:0]  shadow_rank [NSETS*NWAYS];
    logic [31:0] shadow_misses, shadow_accesses;
    logic [3:0]  geo_offset, geo_sets;
    logic [1:0]  geo_ways;

    logic [63:0]  addr_queue [$];
    lookup_res_t  expected_lookups [$];
    int  accepted_count, mismatch_count;
    int  hold_mark;
    bit  quiet_phase, hold_sender, long_hold_req;
    longint cycle_count;

    function automatic int clamp_bits(int bits, int cap);
        int b;
        b = bits;
        while (b > 0 && (1 << b) > cap) b--;
        return b;
    endfunction

    task automatic flush_shadow();
        for (int i = 0; i < NSETS*NWAYS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i] = '0;
        end
    endtask

    // true-LRU lookup on the shadow copy
    function automatic lookup_res_t predict_lookup(logic [63:0] addr);
        lookup_res_t r;
        int sb, wb, nw, ob, set_idx, base, chosen, old_rank, best;
        logic [63:0] tag;
        bit hit, free_found;
        sb = clamp_bits(geo_sets, NSETS);
        wb = clamp_bits(geo_ways, NWAYS);
        nw = 1 << wb;
        ob = geo_offset;
        set_idx = int'((addr >> ob) & ((64'd1 << sb) - 1));
        tag = addr >> (ob + sb);
        base = set_idx * NWAYS;
        hit = 0; free_found = 0; chosen = 0;
        r.evicted = 1'b0;
        for (int w = 0; w < nw; w++)
            if (!hit && shadow_valid[base+w] && shadow_tag[base+w] == tag) begin
                hit = 1; chosen = w;
            end
        if (!hit) begin
            for (int w = 0; w < nw; w++)
                if (!free_found && !shadow_valid[base+w]) begin
                    free_found = 1; chosen = w;
                end
            if (!free_found) begin
                best = 0; chosen = 0;
                for (int w = 0; w < nw; w++)
                    if (shadow_rank[base+w] > best) begin
                        best = shadow_rank[base+w]; chosen = w;
                    end
                r.evicted = 1'b1;
            end
        end
        old_rank = shadow_valid[base+chosen] ? shadow_rank[base+chosen] : nw;
        for (int w = 0; w < nw; w++)
            if (w != chosen && shadow_valid[base+w] && shadow_rank[base+w] < old_rank)
                shadow_rank[base+w]++;
        shadow_rank[base+chosen] = '0;
        shadow_valid[base+chosen] = 1'b1;
        shadow_tag[base+chosen] = tag;
        if (shadow_accesses != '1) shadow_accesses++;
        if (!hit && shadow_misses != '1) shadow_misses++;
        r.hit = hit;
        r.way_used = chosen[2:0];
        r.miss_total = shadow_misses;
        r.access_total = shadow_accesses;
        return r;
    endfunction

    task automatic wait_drained();
        while (addr_queue.size() != 0 || expected_lookups.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_geometry(logic [1:0] idx, logic [3:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_OFFSET_BITS: begin
                geo_offset = val;
                flush_shadow();
            end
            CFG_SET_BITS: begin
                geo_sets = val;
                flush_shadow();
            end
            CFG_WAY_BITS: begin
                geo_ways = val[1:0];
                flush_shadow();
            end
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [3:0] ob, logic [3:0] sb, logic [1:0] wb);
        write_geometry(CFG_OFFSET_BITS, ob);
        write_geometry(CFG_SET_BITS, sb);
        write_geometry(CFG_WAY_BITS, {2'b00, wb});
    endtask

    // addresses mostly from a small working set so hits and evictions occur
    function automatic logic [63:0] pick_addr();
        logic [63:0] a;
        int sb;
        sb = clamp_bits(geo_sets, NSETS);
        if ($urandom_range(0, 9) < 2) return {$urandom, $urandom};
        a = 64'($urandom_range(0, 3)) << ($urandom_range(0, 1) ? 0 : 40);
        a = (a << sb) | 64'($urandom_range(0, (1 << sb) - 1) & 3);
        a = (a << geo_offset) | ({$urandom, $urandom} & ((64'd1 << geo_offset) - 1));
        if ($urandom_range(0, 15) == 0) a[63] = 1'b1;
        return a;
    endfunction

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) addr_queue.push_back(pick_addr());
        wait_drained();
    endtask

    // sender: offers queued addresses with random gaps
    int send_gap;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_lookups.push_back(predict_lookup(s_tdata));
                accepted_count++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!(s_tvalid && !s_tready)) begin
                if (addr_queue.size() != 0 && !hold_sender &&
                    (quiet_phase || $urandom_range(0, 5) != 0)) begin
                    s_tdata <= addr_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                    if (!quiet_phase && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 9);
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    int recv_gap, long_hold;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (long_hold_req && long_hold == 0) long_hold <= 200;
            if (long_hold > 1) begin
                long_hold <= long_hold - 1;
                m_tready <= 1'b0;
            end else if (long_hold == 1) begin
                long_hold <= 0;
                long_hold_req <= 1'b0;
                m_tready <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        lookup_res_t exp_r, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tdata[0];
            got.way_used = m_tdata[3:1];
            got.evicted = m_tdata[4];
            got.miss_total = m_tdata[36:5];
            got.access_total = m_tdata[68:37];
            if (expected_lookups.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                exp_r = expected_lookups.pop_front();
                if (got != exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp hit=%0d way=%0d ev=%0d miss=%0d acc=%0d, got hit=%0d way=%0d ev=%0d miss=%0d acc=%0d",
                            exp_r.hit, exp_r.way_used, exp_r.evicted, exp_r.miss_total,
                            exp_r.access_total, got.hit, got.way_used, got.evicted,
                            got.miss_total, got.access_total);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        geo_offset = 0; geo_sets = 0; geo_ways = 0;
        shadow_misses = 0; shadow_accesses = 0;
        for (int i = 0; i < NSETS*NWAYS; i++) shadow_tag[i] = '0;
        flush_shadow();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset geometry, extremes of the address
        addr_queue.push_back(64'd0);
        addr_queue.push_back('1);
        addr_queue.push_back(64'd0);
        addr_queue.push_back(64'h5555_5555_5555_5555);
        addr_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        wait_drained();
        // full geometry: 8 ways, fill one set, then evict the LRU way
        set_geometry(4'd4, 4'd8, 2'd3);
        for (int i = 0; i < 10; i++) addr_queue.push_back(64'(i) << 12);
        addr_queue.push_back(64'd0);
        addr_queue.push_back(64'h1000);
        wait_drained();
        // too many sets get clamped, offset beyond range honored
        set_geometry(4'd15, 4'd15, 2'd3);
        addr_queue.push_back('1);
        addr_queue.push_back(64'hFFFF_FFFF_FFFF_7FFF);
        addr_queue.push_back('1);
        wait_drained();
        // write to an out-of-range index does nothing
        write_geometry(CFG_UNUSED_IDX, 4'hF);
        addr_queue.push_back('1);
        wait_drained();

        // random phases across geometries
        for (int p = 0; p < 8; p++) begin
            set_geometry(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         2'($urandom_range(0, 3)));
            if (p == 2) long_hold_req = 1'b1;
            if (p == 4) begin
                // sender pauses mid-burst until every result is back
                for (int i = 0; i < 90; i++) addr_queue.push_back(pick_addr());
                hold_mark = accepted_count + 40;
                while (accepted_count < hold_mark) @(posedge aclk);
                hold_sender = 1'b1;
                while (s_tvalid || expected_lookups.size() != 0) @(posedge aclk);
                hold_sender = 1'b0;
                wait_drained();
            end
            random_burst((p == 4) ? 90 : 180);
        end
        set_geometry(4'd0, 4'd0, 2'd0);
        random_burst(60);
        set_geometry(4'd2, 4'd1, 2'd1);
        random_burst(60);
        quiet_phase = 1'b1;
        set_geometry(4'd6, 4'd3, 2'd2);
        random_burst(120);

        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
